// ===== design/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell balancing controller package
// Shared constants, types and register map for the balancing block.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int MaxCells    = 12;
  localparam int TempSensors = 2;
  localparam int CellW       = $clog2(MaxCells);
  localparam int SensW       = (TempSensors > 1) ? $clog2(TempSensors) : 1;

  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeBal  = 2'd1;
  localparam logic [1:0] ModeCool = 2'd2;

  localparam logic [3:0] RegCellCount = 4'd0;
  localparam logic [3:0] RegMaxTemp   = 4'd1;
  localparam logic [3:0] RegMinVolt   = 4'd2;
  localparam logic [3:0] RegTempHyst  = 4'd3;

  localparam logic CmdVolt = 1'b0;
  localparam logic CmdTemp = 1'b1;

  // One queued request between the front and the back.
  typedef struct packed {
    logic        cmd;
    logic [3:0]  index;
    logic [15:0] millivolts;
    logic [9:0]  temperature;
    logic        charging;
    logic        last;
  } req_t;

  typedef struct packed {
    logic [3:0]        cell_count;
    logic signed [9:0] temp_limit;
    logic [15:0]       min_cell_voltage;
    logic [7:0]        temp_hysteresis;
  } cfg_t;

endpackage

// ===== design/cbc_front.sv =====
// ----------------------------------------------------------------------------
// Front end and request queue
// Accepts scan items into a small FIFO so the balancer runs decoupled.
// ----------------------------------------------------------------------------
module cbc_front import cbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output req_t q_req_o
);

  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

// ===== design/cbc_back.sv =====
// ----------------------------------------------------------------------------
// Balancer back end
// Stores scan data and, on the last item, runs the mode step over the cells.
// ----------------------------------------------------------------------------
module cbc_back import cbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  req_t        q_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] balance_mask_o,
  output logic [1:0]  mode_o,
  output logic        led_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExt  = 3'd1;
  localparam logic [2:0] StDec  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StRank = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [15:0]       volt_q [MaxCells];
  logic signed [9:0] temp_q [TempSensors];
  logic [1:0]        mode_q;
  logic [CellW-1:0]  ref_q;
  logic [2:0]        st_q;
  logic [CellW:0]    n_q, i_q, j_q, rank_q;
  logic [CellW-1:0]  lo_q;
  logic [15:0]       minv_q, maxv_q;
  logic signed [10:0] hot_q;
  logic [MaxCells-1:0] mask_q;
  logic [CellW:0]    allowed_q;
  logic [19:0]       rem_q;
  logic              out_valid_q;
  logic [11:0]       out_mask_q;
  logic [1:0]        out_mode_q;

  logic [CellW:0] n_eff;
  logic signed [10:0] hot_c;
  logic [CellW-1:0] ii, jj;
  logic signed [11:0] margin;
  logic signed [11:0] hyst_s;
  logic [10:0] abs_m;

  always_comb begin
    if (cfg_i.cell_count == 4'd0) n_eff = (CellW+1)'(1);
    else if ({1'b0, cfg_i.cell_count} > 5'(MaxCells)) n_eff = (CellW+1)'(MaxCells);
    else n_eff = (CellW+1)'(cfg_i.cell_count);
    hot_c = -11'sd1000;
    for (int s = 0; s < TempSensors; s++)
      if (11'(signed'(temp_q[s])) > hot_c) hot_c = 11'(signed'(temp_q[s]));
    ii = i_q[CellW-1:0];
    jj = j_q[CellW-1:0];
    hyst_s = 12'(signed'({1'b0, cfg_i.temp_hysteresis}));
    margin = 12'(signed'(cfg_i.temp_limit)) - 12'(hot_q);
    abs_m  = margin[11] ? 11'(-margin) : 11'(margin);
  end

  wire can_take = (st_q == StIdle) && !(out_valid_q && !out_ready_i);
  assign q_pop_o = can_take && q_valid_i;

  assign out_valid_o    = out_valid_q;
  assign balance_mask_o = out_mask_q;
  assign mode_o         = out_mode_q;
  assign led_o          = (out_mode_q == ModeBal);

  // Signed reference difference and rank comparison for the walk.
  logic signed [16:0] dref;
  logic               beats;
  assign dref  = 17'({1'b0, volt_q[ii]}) - 17'({1'b0, volt_q[ref_q]});
  assign beats = (volt_q[jj] > volt_q[ii]) || (volt_q[jj] == volt_q[ii] && jj < ii);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxCells; k++) volt_q[k] <= '0;
      for (int k = 0; k < TempSensors; k++) temp_q[k] <= '0;
      mode_q <= ModeIdle;
      ref_q <= '0;
      st_q <= StIdle;
      out_valid_q <= 1'b0;
      n_q <= '0; i_q <= '0; j_q <= '0; rank_q <= '0;
      lo_q <= '0; minv_q <= '0; maxv_q <= '0; hot_q <= '0;
      mask_q <= '0; allowed_q <= '0; rem_q <= '0;
      out_mask_q <= '0; out_mode_q <= ModeIdle;
    end else begin
      if (out_valid_q && out_ready_i && st_q != StOut) out_valid_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (q_pop_o) begin
            if (q_req_i.cmd == CmdVolt) begin
              if ({1'b0, q_req_i.index} < 5'(MaxCells))
                volt_q[q_req_i.index[CellW-1:0]] <= q_req_i.millivolts;
            end else if ({1'b0, q_req_i.index} < 5'(TempSensors)) begin
              temp_q[q_req_i.index[SensW-1:0]] <= q_req_i.temperature;
            end
            if (q_req_i.last) begin
              mask_q <= '0;
              if (q_req_i.charging) begin
                mode_q <= ModeIdle;
                st_q <= StOut;
                out_mode_q <= ModeIdle;
              end else begin
                n_q <= n_eff;
                i_q <= '0;
                minv_q <= 16'hFFFF;
                maxv_q <= '0;
                lo_q <= '0;
                st_q <= StExt;
              end
            end
          end
        end
        StExt: begin
          // Operand writes from this request are now visible.
          hot_q <= hot_c;
          if (i_q == '0) begin
            minv_q <= volt_q[0]; lo_q <= '0;
            maxv_q <= volt_q[0];
            i_q <= (CellW+1)'(1);
          end else if (i_q < n_q) begin
            if (volt_q[ii] < minv_q) begin minv_q <= volt_q[ii]; lo_q <= ii; end
            if (volt_q[ii] > maxv_q) maxv_q <= volt_q[ii];
            i_q <= i_q + 1'b1;
          end else begin
            st_q <= StDec;
          end
        end
        StDec: begin
          case (mode_q)
            ModeIdle: begin
              ref_q <= lo_q;
              if (maxv_q - minv_q > 16'd50) mode_q <= ModeBal;
              st_q <= StOut;
            end
            ModeBal: begin
              if (hot_q >= 11'(signed'(cfg_i.temp_limit))) begin
                mode_q <= ModeCool;
                st_q <= StOut;
              end else if ({1'b0, ref_q} >= n_q) begin
                mode_q <= ModeIdle;
                st_q <= StOut;
              end else if ((maxv_q > volt_q[ref_q] ? maxv_q - volt_q[ref_q]
                                                   : volt_q[ref_q] - maxv_q) < 16'd20
                           || minv_q <= cfg_i.min_cell_voltage) begin
                mode_q <= ModeIdle;
                st_q <= StOut;
              end else if ({1'b0, volt_q[ref_q]} > {1'b0, minv_q} + 17'd4) begin
                mode_q <= ModeIdle;
                st_q <= StOut;
              end else if (margin < hyst_s && cfg_i.temp_hysteresis != 8'd0) begin
                rem_q <= 20'(abs_m) * 20'(n_q);
                allowed_q <= '0;
                st_q <= StDiv;
              end else begin
                allowed_q <= n_q;
                i_q <= '0; j_q <= '0; rank_q <= '0;
                st_q <= StRank;
              end
            end
            ModeCool: begin
              if (12'(hot_q) < 12'(signed'(cfg_i.temp_limit)) - hyst_s)
                mode_q <= ModeBal;
              st_q <= StOut;
            end
            default: begin
              mode_q <= ModeIdle;
              st_q <= StOut;
            end
          endcase
        end
        StDiv: begin
          // Repeated subtraction; quotient saturates at the cell count.
          if (rem_q >= 20'(cfg_i.temp_hysteresis) && allowed_q < n_q) begin
            rem_q <= rem_q - 20'(cfg_i.temp_hysteresis);
            allowed_q <= allowed_q + 1'b1;
          end else begin
            i_q <= '0; j_q <= '0; rank_q <= '0;
            st_q <= StRank;
          end
        end
        StRank: begin
          if (j_q < n_q) begin
            if (beats) rank_q <= rank_q + 1'b1;
            j_q <= j_q + 1'b1;
          end else begin
            if (rank_q < allowed_q && ii != ref_q && dref > 17'sd10) mask_q[ii] <= 1'b1;
            j_q <= '0; rank_q <= '0;
            if (i_q + 1'b1 < n_q) i_q <= i_q + 1'b1;
            else st_q <= StOut;
          end
        end
        StOut: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_mask_q  <= 12'(mask_q);
            out_mode_q  <= mode_q;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== design/cell_balancing_controller_unit.sv =====
// Flow: an accepted item waits in the front queue and is stored when the back end pops it;
// a last item then runs the extremes walk and a decision step (charging skips both), and
// in balance mode may add a divide and a rank walk, before the output step.
// Throughput is one plain item per cycle while the back end is idle and its output is not
// stalled; a two-entry queue keeps the input open while the back end works on a scan,
// until it fills. Reset clears cell and sensor data and mode and loads the default config.
// ----------------------------------------------------------------------------
// Cell balancing controller
// Top level: APB register file, front queue and balancer back end.
// ----------------------------------------------------------------------------
module cell_balancing_controller_unit import cbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [3:0]  index_i,
  input  logic [15:0] millivolts_i,
  input  logic signed [9:0] temperature_i,
  input  logic        charging_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] balance_mask_o,
  output logic [1:0]  mode_o,
  output logic        led_o
);

  cfg_t cfg_q;
  req_t in_req, q_req;
  logic q_valid, q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_count       <= 4'd12;
      cfg_q.temp_limit       <= 10'sd50;
      cfg_q.min_cell_voltage <= 16'd3000;
      cfg_q.temp_hysteresis  <= 8'd5;
    end else if (psel && penable && pwrite) begin
      case ({2'b00, paddr[3:2]})
        RegCellCount: cfg_q.cell_count       <= pwdata[3:0];
        RegMaxTemp:   cfg_q.temp_limit       <= pwdata[9:0];
        RegMinVolt:   cfg_q.min_cell_voltage <= pwdata[15:0];
        RegTempHyst:  cfg_q.temp_hysteresis  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case ({2'b00, paddr[3:2]})
      RegCellCount: prdata = {28'd0, cfg_q.cell_count};
      RegMaxTemp:   prdata = 32'(signed'(cfg_q.temp_limit));
      RegMinVolt:   prdata = {16'd0, cfg_q.min_cell_voltage};
      RegTempHyst:  prdata = {24'd0, cfg_q.temp_hysteresis};
      default:      prdata = '0;
    endcase
  end

  assign in_req = '{cmd: cmd_i, index: index_i, millivolts: millivolts_i,
                    temperature: temperature_i, charging: charging_i, last: last_i};

  cbc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i(in_req),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  cbc_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_req_i(q_req), .out_valid_o, .out_ready_i, .balance_mask_o, .mode_o, .led_o
  );

endmodule
